// ----- src/pillar_split_z_expander_core_assert.svh -----
// Assertion macros used by the expander core.
`ifndef PILLAR_SPLIT_Z_EXPANDER_CORE_ASSERT_SVH
`define PILLAR_SPLIT_Z_EXPANDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSZX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold starting in the cycle after the antecedent.
`define PSZX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pszx_pkg.sv -----
`timescale 1ns / 1ps

package pszx_pkg;

  localparam int MAX_PILLAR_SLOTS_DEF = 64;

  localparam int Z_W        = 32;
  localparam int CODE_W     = 8;
  localparam int LAYER_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CODE_W-1:0] CODE_SINGLE = 8'd1;
  localparam logic [CODE_W-1:0] CODE_QUAD   = 8'd4;

  localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_SCALE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_NODES = 2'd2;

  localparam logic signed [Z_W-1:0] Z_OFFSET_RESET    = 32'sd0;
  localparam logic signed [Z_W-1:0] Z_SCALE_RESET     = 32'sd16777216;
  localparam logic [LAYER_W-1:0]    LAYER_NODES_RESET = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_FILL,
    S_CHECK,
    S_READ,
    S_SHOW,
    S_ERR
  } state_t;

  // Request to the shared transform unit.
  typedef struct packed {
    logic                  start;
    logic signed [Z_W-1:0] z;
  } xf_req_t;

endpackage

// ----- src/pszx_xform.sv -----
`timescale 1ns / 1ps

module pszx_xform (
  input  logic                                clk,
  input  logic                                rst,
  input  pszx_pkg::xf_req_t                   req,
  input  logic signed [pszx_pkg::Z_W-1:0]     z_offset,
  input  logic signed [pszx_pkg::Z_W-1:0]     z_scale,
  output logic                                done,
  output logic signed [pszx_pkg::Z_W-1:0]     result
);

  logic signed [32:0] sum;
  logic [32:0]        ms_in;
  logic [31:0]        mc_in;

  logic        v1;
  logic        neg1;
  logic [32:0] ms;
  logic [31:0] mc;

  logic        v2;
  logic        neg2;
  logic [64:0] prod;

  logic [64:0] rnd;
  logic [40:0] mag;
  logic [31:0] res_next;

  // Stage 1: exact offset sum and sign/magnitude split.
  always_comb begin
    sum   = 33'(req.z) + 33'(z_offset);
    ms_in = sum[32] ? (33'd0 - 33'(sum)) : 33'(sum);
    mc_in = z_scale[31] ? (32'd0 - 32'(z_scale)) : 32'(z_scale);
  end

  // Stage 3: round half away from zero on the magnitude, then saturate.
  always_comb begin
    rnd = prod + 65'(24'h800000);
    mag = rnd[64:24];
    if (neg2) begin
      if (mag >= 41'h0080000000) begin
        res_next = 32'h80000000;
      end else begin
        res_next = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 41'h007FFFFFFF) begin
        res_next = 32'h7FFFFFFF;
      end else begin
        res_next = mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.start;
      v2   <= v1;
      done <= v2;
    end
    neg1   <= sum[32] ^ z_scale[31];
    ms     <= ms_in;
    mc     <= mc_in;
    neg2   <= neg1;
    prod   <= 65'(ms) * 65'(mc);
    result <= res_next;
  end

endmodule

// ----- src/pszx_store.sv -----
`timescale 1ns / 1ps

module pszx_store #(
  parameter int DEPTH = pszx_pkg::MAX_PILLAR_SLOTS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [pszx_pkg::Z_W-1:0]    wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [pszx_pkg::Z_W-1:0]    rdata
);

  logic [pszx_pkg::Z_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pillar_split_z_expander_core.sv -----
`timescale 1ns / 1ps
// Pillar split-code expander. Each input item carries a split code and four
// raw z samples; each sample used is transformed as (z + z_offset) * z_scale
// with rounding and saturation, and four pillar slots are filled per item.
// Code 1 fills four slots with one value, code 4 with four values in reverse
// order. Any other code returns one item with status 1 and drops the pillar.
// When 4*layer_nodes slots (count clamped) are full, the pillar is sent
// out highest slot first, one per output item, last_of_pillar on slot 0.
// Both channels use valid/ready; configuration is a plain write port and
// must only be written while the block is idle.
// Transforms run in the shared three-stage multiply unit, and samples go
// through it one at a time. A code 1 item transforms one sample and then
// writes it to four slots, one store write per cycle; a code 4 item writes
// each result as it arrives. An error item is sent once the output register
// is free. Each emitted value takes a store read, then a load of the output
// register once it is free. in_ready is high only between items.
// If the receiver stalls, the output register holds its item and the
// sequencer waits; no item is lost. Reset returns the registers to their
// defaults and empties the pillar; store contents are not cleared.
module pillar_split_z_expander_core #(
  parameter int MAX_PILLAR_SLOTS = pszx_pkg::MAX_PILLAR_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [pszx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pszx_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pszx_pkg::CODE_W-1:0]          split_code,
  input  logic signed [pszx_pkg::Z_W-1:0]      z_first,
  input  logic signed [pszx_pkg::Z_W-1:0]      z_second,
  input  logic signed [pszx_pkg::Z_W-1:0]      z_third,
  input  logic signed [pszx_pkg::Z_W-1:0]      z_fourth,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pszx_pkg::Z_W-1:0]      corner_z,
  output logic                                 last_of_pillar,
  output logic                                 status
);

  `include "pillar_split_z_expander_core_assert.svh"

  localparam int SLOT_W    = $clog2(MAX_PILLAR_SLOTS);
  localparam int FILL_W    = $clog2(MAX_PILLAR_SLOTS + 1);
  localparam int MAX_NODES = MAX_PILLAR_SLOTS / 4;

  pszx_pkg::state_t state, state_next;

  logic signed [pszx_pkg::Z_W-1:0] z_offset;
  logic signed [pszx_pkg::Z_W-1:0] z_scale;
  logic [pszx_pkg::LAYER_W-1:0]    layer_nodes;

  logic signed [pszx_pkg::Z_W-1:0] z_hold [4];
  logic                            quad;
  logic [1:0]                      smp;
  logic [1:0]                      wcnt;
  logic [FILL_W-1:0]               fill;
  logic [FILL_W-1:0]               p_base;
  logic [SLOT_W-1:0]               idx;

  logic                   in_accept;
  logic                   code_ok;
  logic                   overflow;
  logic                   out_free;
  logic [pszx_pkg::LAYER_W-1:0] nodes;
  logic [FILL_W-1:0]      rows;
  logic [FILL_W-1:0]      p_sum;

  pszx_pkg::xf_req_t               xf_req;
  logic                            xf_done;
  logic signed [pszx_pkg::Z_W-1:0] xf_result;

  logic                         mem_we;
  logic [SLOT_W-1:0]            mem_waddr;
  logic [SLOT_W-1:0]            mem_raddr;
  logic [pszx_pkg::Z_W-1:0]     mem_rdata;
  logic                         load_val;
  logic                         load_err;

  pszx_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .req      (xf_req),
    .z_offset (z_offset),
    .z_scale  (z_scale),
    .done     (xf_done),
    .result   (xf_result)
  );

  pszx_store #(
    .DEPTH  (MAX_PILLAR_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (xf_result),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state == pszx_pkg::S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign code_ok   = split_code inside {pszx_pkg::CODE_SINGLE, pszx_pkg::CODE_QUAD};
  assign overflow  = ({1'b0, fill} + (FILL_W + 1)'(4)) > (FILL_W + 1)'(MAX_PILLAR_SLOTS);
  assign p_sum     = p_base + FILL_W'(4);
  assign mem_raddr = idx;

  // Pillar length in slots, with the layer count clamped to at least one and to the store size.
  always_comb begin
    if (layer_nodes == '0) begin
      nodes = pszx_pkg::LAYER_W'(1);
    end else if (layer_nodes > pszx_pkg::LAYER_W'(MAX_NODES)) begin
      nodes = pszx_pkg::LAYER_W'(MAX_NODES);
    end else begin
      nodes = layer_nodes;
    end
    rows = FILL_W'({nodes, 2'b00});
  end

  always_comb begin
    state_next = state;
    case (state)
      pszx_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!code_ok) begin
            state_next = pszx_pkg::S_ERR;
          end else if (!overflow) begin
            state_next = pszx_pkg::S_LAUNCH;
          end
        end
      end
      pszx_pkg::S_LAUNCH: state_next = pszx_pkg::S_WAIT;
      pszx_pkg::S_WAIT: begin
        if (xf_done) begin
          if (!quad) begin
            state_next = pszx_pkg::S_FILL;
          end else if (smp == 2'd3) begin
            state_next = pszx_pkg::S_CHECK;
          end else begin
            state_next = pszx_pkg::S_LAUNCH;
          end
        end
      end
      pszx_pkg::S_FILL: begin
        if (wcnt == 2'd3) begin
          state_next = pszx_pkg::S_CHECK;
        end
      end
      pszx_pkg::S_CHECK: begin
        state_next = (p_sum >= rows) ? pszx_pkg::S_READ : pszx_pkg::S_IDLE;
      end
      pszx_pkg::S_READ: begin
        if (out_free) begin
          state_next = pszx_pkg::S_SHOW;
        end
      end
      pszx_pkg::S_SHOW: begin
        state_next = (idx == '0) ? pszx_pkg::S_IDLE : pszx_pkg::S_READ;
      end
      pszx_pkg::S_ERR: begin
        if (out_free) begin
          state_next = pszx_pkg::S_IDLE;
        end
      end
      default: state_next = pszx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    xf_req.start = (state == pszx_pkg::S_LAUNCH);
    xf_req.z     = z_hold[smp];
    mem_we       = (state == pszx_pkg::S_FILL) ||
                   ((state == pszx_pkg::S_WAIT) && xf_done && quad);
    // Code 4 stores the first sample in the highest of the four slots.
    if (quad) begin
      mem_waddr = SLOT_W'(p_base + FILL_W'(2'd3 - smp));
    end else begin
      mem_waddr = SLOT_W'(p_base + FILL_W'(wcnt));
    end
    load_val = (state == pszx_pkg::S_SHOW);
    load_err = (state == pszx_pkg::S_ERR) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pszx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z_offset    <= pszx_pkg::Z_OFFSET_RESET;
      z_scale     <= pszx_pkg::Z_SCALE_RESET;
      layer_nodes <= pszx_pkg::LAYER_NODES_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        pszx_pkg::REG_Z_OFFSET:    z_offset    <= cfg_data;
        pszx_pkg::REG_Z_SCALE:     z_scale     <= cfg_data;
        pszx_pkg::REG_LAYER_NODES: layer_nodes <= cfg_data[pszx_pkg::LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (in_accept && (!code_ok || overflow)) begin
      fill <= '0;
    end else if (state == pszx_pkg::S_CHECK) begin
      fill <= (p_sum >= rows) ? '0 : p_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      z_hold[0] <= z_first;
      z_hold[1] <= z_second;
      z_hold[2] <= z_third;
      z_hold[3] <= z_fourth;
      quad      <= (split_code == pszx_pkg::CODE_QUAD);
      p_base    <= fill;
      smp       <= '0;
    end else if ((state == pszx_pkg::S_WAIT) && xf_done && quad) begin
      smp <= smp + 2'd1;
    end
    if (state == pszx_pkg::S_WAIT) begin
      wcnt <= '0;
    end else if (state == pszx_pkg::S_FILL) begin
      wcnt <= wcnt + 2'd1;
    end
    if (state == pszx_pkg::S_CHECK) begin
      idx <= SLOT_W'(rows - FILL_W'(1));
    end else if ((state == pszx_pkg::S_SHOW) && (idx != '0)) begin
      idx <= idx - SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_val || load_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_val) begin
      corner_z       <= mem_rdata;
      last_of_pillar <= (idx == '0);
      status         <= 1'b0;
    end else if (load_err) begin
      corner_z       <= '0;
      last_of_pillar <= 1'b0;
      status         <= 1'b1;
    end
  end

  `PSZX_ASSERT_SAME(a_show_reg_free, clk, rst, state == pszx_pkg::S_SHOW, !out_valid,
    "output register still occupied when a store value is loaded")
  `PSZX_ASSERT_SAME(a_write_in_group, clk, rst, mem_we,
    (FILL_W'(mem_waddr) >= p_base) && (FILL_W'(mem_waddr) < p_sum),
    "store write outside the four slots of the current item")
  `PSZX_ASSERT_SAME(a_fill_aligned, clk, rst, state == pszx_pkg::S_IDLE,
    (fill[1:0] == 2'b00) && (fill < FILL_W'(MAX_PILLAR_SLOTS)),
    "fill position not a whole group of four inside the store")
  `PSZX_ASSERT_NEXT(a_xform_latency, clk, rst, xf_req.start, (##2 xf_done),
    "transform unit did not finish three cycles after start")

endmodule
